// File: hw/rtl/hse_pkg.sv
`timescale 1ns / 1ps

package hse_pkg;

  // input beat kinds, carried on in_tuser
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_DATA = 1'b1
  } in_cmd_t;

  localparam int ENTRY_INDEX_W = 10;
  localparam int SYM_W         = 16;
  localparam int CODE_W        = 29;
  localparam int LEN_W         = 5;
  localparam int BYTE_W        = 8;
  localparam int CFG_W         = 11;

  // in_tdata layout, lowest bit up
  localparam int INDEX_LSB  = 0;
  localparam int SYM_LSB    = INDEX_LSB + ENTRY_INDEX_W;
  localparam int CODE_LSB   = SYM_LSB + SYM_W;
  localparam int LEN_LSB    = CODE_LSB + CODE_W;
  localparam int DATA_LSB   = LEN_LSB + LEN_W;
  localparam int IN_TDATA_W = 72;

  // out_tdata: out_byte, then symbol_missing
  localparam int OUT_TDATA_W = 16;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } tbl_entry_t;

  typedef struct packed {
    logic load_wr;
    logic data_take;
    logic scan_step;
    logic emit_data;
    logic emit_pad;
    logic emit_count;
  } ctl_cmd_t;

  typedef struct packed {
    logic have_sym;
    logic scan_done;
    logic cnt_ge8;
    logic cnt_zero;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

// File: hw/rtl/huffman_stream_encoder_top.sv
// Table-driven Huffman encoder. A load beat (in_tuser 0) writes one code-table slot as it
// is accepted. A data beat (in_tuser 1) that holds a lead byte is only stored; any other
// data beat is accepted, then drives a linear scan of the code table memory, one entry
// per cycle through its single read port (over at most N entries, N = entries in use
// capped at TABLE_DEPTH), then emits each packed byte as the output register frees, and
// on the last byte a pad beat (only if bits remain) and a count beat. Output beats wait
// in a one-deep output register. The table comes up unwritten; set entries_in_use on the
// cfg channel only while the encoder is idle.
`timescale 1ns / 1ps

module huffman_stream_encoder_top #(
  parameter int TABLE_DEPTH   = 1024,
  parameter int MAX_CODE_BITS = 29
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // entry_index[9:0], entry_symbol[25:10], entry_code[54:26], entry_length[59:55],
  // data_byte[67:60], zero fill [71:68]
  input  logic [hse_pkg::IN_TDATA_W-1:0]    in_tdata,
  // cmd
  input  logic                              in_tuser,
  input  logic                              in_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hse_pkg::CFG_W-1:0]         cfg_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_byte[7:0], symbol_missing[8], zero fill [15:9]
  output logic [hse_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // is_pad_count
  output logic                              out_tuser,
  output logic                              out_tlast
);

  hse_pkg::ctl_cmd_t   cmd;
  hse_pkg::dp_status_t st;

  assign cfg_ready = 1'b1;

  hse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  hse_datapath #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_we     (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: hw/rtl/hse_ctrl.sv
`timescale 1ns / 1ps

module hse_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tuser,
  output logic                  in_tready,
  input  hse_pkg::dp_status_t   st,
  output hse_pkg::ctl_cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_EMIT  = 5'b00100,
    S_PAD   = 5'b01000,
    S_COUNT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == hse_pkg::CMD_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.data_take = 1'b1;
            // a held lead byte produces nothing until its partner arrives
            if (st.have_sym) state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.cnt_ge8) begin
          if (st.out_free) cmd.emit_data = 1'b1;
        end else if (st.last) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PAD: begin
        if (st.cnt_zero) begin
          state_nxt = S_COUNT;
        end else if (st.out_free) begin
          cmd.emit_pad = 1'b1;
          state_nxt    = S_COUNT;
        end
      end
      S_COUNT: begin
        if (st.out_free) begin
          cmd.emit_count = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/hse_datapath.sv
`timescale 1ns / 1ps

module hse_datapath #(
  parameter int TABLE_DEPTH   = 1024,
  parameter int MAX_CODE_BITS = 29
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hse_pkg::ctl_cmd_t                 cmd,
  output hse_pkg::dp_status_t               st,
  input  logic [hse_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              in_tlast,
  input  logic                              cfg_we,
  input  logic [hse_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [hse_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tuser,
  output logic                              out_tlast
);

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SCAN_W  = IDX_W + 1;
  localparam int LEN_MAX = (MAX_CODE_BITS < 31) ? MAX_CODE_BITS : 31;
  localparam int BUF_W   = LEN_MAX + 7;
  localparam int CNT_W   = $clog2(BUF_W + 1);
  localparam int LW      = hse_pkg::LEN_W;
  localparam int CW      = hse_pkg::CODE_W;
  localparam int SW      = hse_pkg::SYM_W;
  localparam int BW      = hse_pkg::BYTE_W;
  localparam int IW      = hse_pkg::ENTRY_INDEX_W;

  // code table, undefined until loaded
  hse_pkg::tbl_entry_t mem [TABLE_DEPTH];
  hse_pkg::tbl_entry_t rd_data_r;
  hse_pkg::tbl_entry_t wr_entry;

  logic [hse_pkg::CFG_W-1:0] eiu_r;
  logic [SCAN_W-1:0]         limit;
  logic [SCAN_W-1:0]         scan_idx_r, scan_idx_nxt;
  logic                      rd_pend_r, rd_pend_nxt;
  logic                      rd_en;
  logic [SW-1:0]             sym_r, sym_nxt;
  logic [BW-1:0]             lead_r, lead_nxt;
  logic                      lead_valid_r, lead_valid_nxt;
  logic                      last_r, last_nxt;
  logic                      miss_r, miss_nxt;
  logic [BUF_W-1:0]          buf_r, buf_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [2:0]                pad_r, pad_nxt;
  logic                      hit, miss;

  logic                      out_valid_r, out_valid_nxt;
  logic [BW-1:0]             out_byte_r, out_byte_nxt;
  logic                      out_pad_r, out_pad_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      out_miss_r, out_miss_nxt;
  logic                      out_free;

  logic [IW-1:0]             idx_in;
  logic [LW-1:0]             len_in, len_sat;
  logic [CW-1:0]             code_in, ones;
  logic [BW-1:0]             byte_in;
  logic                      wr_en;

  assign idx_in  = in_tdata[hse_pkg::INDEX_LSB +: IW];
  assign len_in  = in_tdata[hse_pkg::LEN_LSB +: LW];
  assign code_in = in_tdata[hse_pkg::CODE_LSB +: CW];
  assign byte_in = in_tdata[hse_pkg::DATA_LSB +: BW];
  assign ones    = '1;

  always_comb begin
    len_sat = len_in;
    if (int'(len_in) > MAX_CODE_BITS) len_sat = LW'(MAX_CODE_BITS);
    wr_entry.sym  = in_tdata[hse_pkg::SYM_LSB +: SW];
    wr_entry.code = code_in & ~(ones << len_sat);
    wr_entry.len  = len_sat;
  end

  assign wr_en = cmd.load_wr && (int'(idx_in) < TABLE_DEPTH);

  assign limit = (int'(eiu_r) > TABLE_DEPTH) ? SCAN_W'(TABLE_DEPTH) : SCAN_W'(eiu_r);
  assign rd_en = cmd.scan_step && (scan_idx_r < limit);

  always_ff @(posedge clk) begin
    if (wr_en) mem[IDX_W'(idx_in)] <= wr_entry;
    if (rd_en) rd_data_r <= mem[scan_idx_r[IDX_W-1:0]];
  end

  assign hit      = rd_pend_r && (rd_data_r.sym == sym_r);
  assign miss     = !hit && (scan_idx_r >= limit);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    st.have_sym  = lead_valid_r || !byte_in[BW-1] || in_tlast;
    st.scan_done = hit || miss;
    st.cnt_ge8   = cnt_r >= CNT_W'(8);
    st.cnt_zero  = cnt_r == '0;
    st.last      = last_r;
    st.out_free  = out_free;
  end

  always_comb begin
    scan_idx_nxt   = scan_idx_r;
    rd_pend_nxt    = rd_pend_r;
    sym_nxt        = sym_r;
    lead_nxt       = lead_r;
    lead_valid_nxt = lead_valid_r;
    last_nxt       = last_r;
    miss_nxt       = miss_r;
    buf_nxt        = buf_r;
    cnt_nxt        = cnt_r;
    pad_nxt        = pad_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_byte_nxt   = out_byte_r;
    out_pad_nxt    = out_pad_r;
    out_last_nxt   = out_last_r;
    out_miss_nxt   = out_miss_r;

    if (cmd.data_take) begin
      last_nxt     = in_tlast;
      pad_nxt      = '0;
      scan_idx_nxt = '0;
      rd_pend_nxt  = 1'b0;
      if (lead_valid_r) begin
        sym_nxt        = {lead_r, byte_in};
        lead_valid_nxt = 1'b0;
        lead_nxt       = '0;
      end else if (byte_in[BW-1] && !in_tlast) begin
        lead_nxt       = byte_in;
        lead_valid_nxt = 1'b1;
      end else begin
        sym_nxt = {byte_in, {BW{1'b0}}};
      end
    end

    // scan: one address issued per cycle, each entry compared in the cycle after its read
    if (cmd.scan_step) begin
      rd_pend_nxt = rd_en;
      if (rd_en) scan_idx_nxt = scan_idx_r + SCAN_W'(1);
      if (hit) begin
        buf_nxt = (buf_r << rd_data_r.len) | BUF_W'(rd_data_r.code);
        cnt_nxt = cnt_r + CNT_W'(rd_data_r.len);
      end else if (miss) begin
        miss_nxt = 1'b1;
      end
    end

    if (cmd.emit_data) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = BW'(buf_r >> (cnt_r - CNT_W'(8)));
      out_pad_nxt   = 1'b0;
      out_last_nxt  = 1'b0;
      out_miss_nxt  = miss_r;
      cnt_nxt       = cnt_r - CNT_W'(8);
    end

    if (cmd.emit_pad) begin
      pad_nxt       = 3'(4'd8 - {1'b0, cnt_r[2:0]});
      out_valid_nxt = 1'b1;
      out_byte_nxt  = BW'(buf_r[BW-1:0] << (4'd8 - {1'b0, cnt_r[2:0]}));
      out_pad_nxt   = 1'b0;
      out_last_nxt  = 1'b0;
      out_miss_nxt  = miss_r;
      cnt_nxt       = '0;
      buf_nxt       = '0;
    end

    if (cmd.emit_count) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = {{(BW-3){1'b0}}, pad_r};
      out_pad_nxt   = 1'b1;
      out_last_nxt  = 1'b1;
      out_miss_nxt  = miss_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eiu_r        <= '0;
      rd_pend_r    <= 1'b0;
      lead_valid_r <= 1'b0;
      lead_r       <= '0;
      miss_r       <= 1'b0;
      buf_r        <= '0;
      cnt_r        <= '0;
      last_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) eiu_r <= cfg_data;
      rd_pend_r    <= rd_pend_nxt;
      lead_valid_r <= lead_valid_nxt;
      lead_r       <= lead_nxt;
      miss_r       <= miss_nxt;
      buf_r        <= buf_nxt;
      cnt_r        <= cnt_nxt;
      last_r       <= last_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    sym_r      <= sym_nxt;
    pad_r      <= pad_nxt;
    out_byte_r <= out_byte_nxt;
    out_pad_r  <= out_pad_nxt;
    out_last_r <= out_last_nxt;
    out_miss_r <= out_miss_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(hse_pkg::OUT_TDATA_W-BW-1){1'b0}}, out_miss_r, out_byte_r};
  assign out_tuser  = out_pad_r;
  assign out_tlast  = out_last_r;

  a_miss_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    miss_r |=> miss_r)
    else $error("miss flag cleared without reset");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_data || cmd.emit_pad || cmd.emit_count) |-> out_free)
    else $error("beat loaded over an untaken result");

  a_count_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_count |-> (cnt_r == '0))
    else $error("count beat with bits still buffered");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(BUF_W))
    else $error("bit buffer overfilled");

endmodule
